// ===== rtl/hds_pkg.sv =====
// ----------------------------------------------------------------------------
// hds_pkg
// Shared constants, register indexes and types of the heightmap diffuse
// shader.
// ----------------------------------------------------------------------------
`default_nettype none

package hds_pkg;

    // Grid and store geometry.
    localparam int MAX_GRID    = 256;
    localparam int HEIGHT_BITS = 16;
    localparam int IDX_W       = 8;
    localparam int DIM_W       = 9;
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int CELLS       = MAX_GRID * MAX_GRID;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 3;

    // Limits of the grid size registers.
    localparam logic [DIM_W-1:0] GRID_LIM = DIM_W'(MAX_GRID);
    localparam logic [DIM_W-1:0] GRID_MIN = DIM_W'(2);

    // Square of the full intensity level.
    localparam logic [31:0] LEVEL_SQ = 32'd65025;

    // Input item function codes.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_SHADE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_SIZE_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_SIZE_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_SIZE_Z = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS_X  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS_Y  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS_Z  = 3'd7;

    // Decoded configuration: last column and row plus world values.
    typedef struct packed {
        logic [IDX_W-1:0] wm1;
        logic [IDX_W-1:0] dm1;
        logic [CFG_W-1:0] wx;
        logic [CFG_W-1:0] wy;
        logic [CFG_W-1:0] wz;
        logic [CFG_W-1:0] lx;
        logic [CFG_W-1:0] ly;
        logic [CFG_W-1:0] lz;
    } t_cfg;

    // One queued shade request, indexes already clamped to the grid.
    typedef struct packed {
        logic [IDX_W-1:0] x;
        logic [IDX_W-1:0] z;
    } t_shade;

endpackage

`default_nettype wire

// ===== rtl/hds_ram.sv =====
// ----------------------------------------------------------------------------
// hds_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hds_front.sv =====
// ----------------------------------------------------------------------------
// hds_front
// Accepts requests, writes loads into the height store and queues shades.
// ----------------------------------------------------------------------------
`default_nettype none

module hds_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire hds_pkg::t_cfg               i_cfg,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_func,
    input  wire logic [hds_pkg::IDX_W-1:0]   i_x_index,
    input  wire logic [hds_pkg::IDX_W-1:0]   i_z_index,
    input  wire logic [hds_pkg::HEIGHT_BITS-1:0] i_height_value,
    input  wire logic                        i_back_busy,
    output logic                             o_wr_en,
    output logic [hds_pkg::ADDR_W-1:0]       o_wr_addr,
    output logic [hds_pkg::HEIGHT_BITS-1:0]  o_wr_data,
    output logic                             o_q_valid,
    output hds_pkg::t_shade                  o_q_item,
    input  wire logic                        i_q_pop
);

    import hds_pkg::*;

    t_shade     r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       q_full;
    logic       q_empty;
    logic       accept;
    logic       push;
    t_shade     item;

    assign q_full  = (r_cnt == 2'd2);
    assign q_empty = (r_cnt == 2'd0);

    // A load waits until every earlier shade has left the queue and the back end is idle.
    assign o_ready = (i_func == FUNC_SHADE) ? !q_full : (q_empty && !i_back_busy);
    assign accept  = i_valid && o_ready;
    assign push    = accept && (i_func == FUNC_SHADE);

    // Loads go straight to the store.
    assign o_wr_en   = accept && (i_func == FUNC_LOAD);
    assign o_wr_addr = {i_z_index, i_x_index};
    assign o_wr_data = i_height_value;

    // Clamp a shade point onto the grid.
    always_comb begin
        item.x = (i_x_index > i_cfg.wm1) ? i_cfg.wm1 : i_x_index;
        item.z = (i_z_index > i_cfg.dm1) ? i_cfg.dm1 : i_z_index;
    end

    assign o_q_valid = !q_empty;
    assign o_q_item  = r_q[r_rp];

    // Two-entry queue towards the back end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= item;
                r_wp      <= !r_wp;
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
            if (push && !i_q_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!push && i_q_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hds_back.sv =====
// ----------------------------------------------------------------------------
// hds_back
// Shading sequencer: reads the neighbors, builds the normal and light
// vectors on one shared multiplier and a bit-serial divider, and searches
// the intensity.
// ----------------------------------------------------------------------------
`default_nettype none

module hds_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire hds_pkg::t_cfg               i_cfg,
    input  wire logic                        i_q_valid,
    input  wire hds_pkg::t_shade             i_q_item,
    output logic                             o_q_pop,
    output logic                             o_busy,
    output logic                             o_rd_en,
    output logic [hds_pkg::ADDR_W-1:0]       o_rd_addr,
    input  wire logic [hds_pkg::HEIGHT_BITS-1:0] i_rd_data,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [hds_pkg::IDX_W-1:0]        o_intensity,
    output logic [hds_pkg::IDX_W-1:0]        o_grid_x,
    output logic [hds_pkg::IDX_W-1:0]        o_grid_z
);

    import hds_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_RED  = 3'd4;
    localparam logic [2:0] S_DOT  = 3'd5;
    localparam logic [2:0] S_SRCH = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam int DY_SHIFT = HEIGHT_BITS - 4;
    localparam int PY_SHIFT = HEIGHT_BITS - 8;
    localparam int NW       = 60;
    localparam int QW       = 39;
    localparam logic [5:0] DIV_LAST = 6'(QW - 1);

    logic [2:0]             r_st;
    logic [5:0]             r_pc;
    logic [IDX_W-1:0]       r_x;
    logic [IDX_W-1:0]       r_z;
    logic [HEIGHT_BITS-1:0] r_h [5];
    logic [63:0]            r_prod;
    logic [27:0]            r_dyx;
    logic [27:0]            r_dyz;
    logic [31:0]            r_py;
    logic [31:0]            r_t1;
    logic [31:0]            r_t2;
    logic [NW-1:0]          r_nm [3];
    logic [2:0]             r_ns;
    logic [32:0]            r_lm [3];
    logic [2:0]             r_ls;
    logic [QW-1:0]          r_numx;
    logic [QW-1:0]          r_numz;
    logic [QW-1:0]          r_dnum;
    logic [IDX_W-1:0]       r_drem;
    logic                   r_dsel;
    logic [33:0]            r_dot;
    logic [31:0]            r_nn;
    logic [31:0]            r_ll;
    logic [63:0]            r_pr;
    logic [63:0]            r_d2;
    logic [47:0]            r_lo;
    logic [79:0]            r_rhs;
    logic [15:0]            r_tsq;
    logic [7:0]             r_k;
    logic [7:0]             r_bit;
    logic                   r_ovalid;
    logic [IDX_W-1:0]       r_oint;
    logic [IDX_W-1:0]       r_ox;
    logic [IDX_W-1:0]       r_oz;

    logic [31:0]            mul_a;
    logic [31:0]            mul_b;
    logic [IDX_W-1:0]       lf, rt, dn, up;
    logic [IDX_W-1:0]       ax_sel, az_sel;
    logic [HEIGHT_BITS-1:0] dxm, dzm;
    logic                   dx_pos, dz_pos;
    logic [DIM_W-1:0]       two_x, two_z, wm1_e, dm1_e;
    logic                   axneg, azneg;
    logic [DIM_W-1:0]       axm, azm;
    logic [IDX_W-1:0]       div_d;
    logic [IDX_W:0]         rem_sh;
    logic                   div_ge;
    logic [IDX_W:0]         rem_nx;
    logic [QW-1:0]          q_nx;
    logic [33:0]            lp_x, lp_y, lp_z;
    logic [33:0]            l0_val, l1_val, l2_val;
    logic                   n_b8, n_b1, l_b8, l_b1;
    logic [33:0]            dot_term;
    logic                   term_neg;
    logic                   okn, okl, dot_pos;
    logic [7:0]             k_try;
    logic [79:0]            lhs;
    logic                   res_load;

    function automatic logic [32:0] mag34(input logic [33:0] v);
        mag34 = v[33] ? 33'(-v) : v[32:0];
    endfunction

    // Neighbor indexes, held at the grid edges.
    always_comb begin
        lf = (r_x == '0) ? r_x : r_x - 8'd1;
        rt = (r_x == i_cfg.wm1) ? r_x : r_x + 8'd1;
        dn = (r_z == '0) ? r_z : r_z - 8'd1;
        up = (r_z == i_cfg.dm1) ? r_z : r_z + 8'd1;
    end

    // Store read address during the read phase.
    always_comb begin
        ax_sel = r_x;
        az_sel = r_z;
        case (r_pc[2:0])
            3'd1:    ax_sel = lf;
            3'd2:    ax_sel = rt;
            3'd3:    az_sel = dn;
            3'd4:    az_sel = up;
            default: ax_sel = r_x;
        endcase
    end
    assign o_rd_en   = (r_st == S_READ) && (r_pc < 6'd5);
    assign o_rd_addr = {az_sel, ax_sel};

    // Height differences and centered position offsets as sign and magnitude.
    always_comb begin
        dx_pos = r_h[2] > r_h[1];
        dz_pos = r_h[4] > r_h[3];
        dxm    = dx_pos ? r_h[2] - r_h[1] : r_h[1] - r_h[2];
        dzm    = dz_pos ? r_h[4] - r_h[3] : r_h[3] - r_h[4];
        two_x  = {r_x, 1'b0};
        two_z  = {r_z, 1'b0};
        wm1_e  = {1'b0, i_cfg.wm1};
        dm1_e  = {1'b0, i_cfg.dm1};
        axneg  = two_x < wm1_e;
        azneg  = two_z < dm1_e;
        axm    = axneg ? wm1_e - two_x : two_x - wm1_e;
        azm    = azneg ? dm1_e - two_z : two_z - dm1_e;
    end

    // Reduction tests over all three components.
    always_comb begin
        n_b8 = |{r_nm[0][NW-1:23], r_nm[1][NW-1:23], r_nm[2][NW-1:23]};
        n_b1 = |{r_nm[0][NW-1:15], r_nm[1][NW-1:15], r_nm[2][NW-1:15]};
        l_b8 = |{r_lm[0][32:23], r_lm[1][32:23], r_lm[2][32:23]};
        l_b1 = |{r_lm[0][32:15], r_lm[1][32:15], r_lm[2][32:15]};
        okn  = |{r_nm[0], r_nm[1], r_nm[2]};
        okl  = |{r_lm[0], r_lm[1], r_lm[2]};
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_st)
            S_MUL: begin
                case (r_pc)
                    6'd0:    begin mul_a = 32'(dxm);      mul_b = 32'(i_cfg.wy); end
                    6'd1:    begin mul_a = 32'(dzm);      mul_b = 32'(i_cfg.wy); end
                    6'd2:    begin mul_a = 32'(r_h[0]);   mul_b = 32'(i_cfg.wy); end
                    6'd3:    begin mul_a = 32'(i_cfg.wz); mul_b = 32'(i_cfg.wm1); end
                    6'd4:    begin mul_a = 32'(i_cfg.wx); mul_b = 32'(i_cfg.dm1); end
                    6'd5:    begin mul_a = r_t1;          mul_b = 32'(r_dyx); end
                    6'd6:    begin mul_a = r_t2;          mul_b = 32'(r_dyz); end
                    6'd7:    begin mul_a = 32'(i_cfg.wx); mul_b = 32'(i_cfg.wz); end
                    6'd8:    begin mul_a = 32'(axm);      mul_b = 32'(i_cfg.wx); end
                    6'd9:    begin mul_a = 32'(azm);      mul_b = 32'(i_cfg.wz); end
                    default: begin mul_a = '0;            mul_b = '0; end
                endcase
            end
            S_DOT: begin
                case (r_pc)
                    6'd0:  begin mul_a = 32'(r_nm[0][14:0]); mul_b = 32'(r_lm[0][14:0]); end
                    6'd1:  begin mul_a = 32'(r_nm[1][14:0]); mul_b = 32'(r_lm[1][14:0]); end
                    6'd2:  begin mul_a = 32'(r_nm[2][14:0]); mul_b = 32'(r_lm[2][14:0]); end
                    6'd3:  begin mul_a = 32'(r_nm[0][14:0]); mul_b = 32'(r_nm[0][14:0]); end
                    6'd4:  begin mul_a = 32'(r_nm[1][14:0]); mul_b = 32'(r_nm[1][14:0]); end
                    6'd5:  begin mul_a = 32'(r_nm[2][14:0]); mul_b = 32'(r_nm[2][14:0]); end
                    6'd6:  begin mul_a = 32'(r_lm[0][14:0]); mul_b = 32'(r_lm[0][14:0]); end
                    6'd7:  begin mul_a = 32'(r_lm[1][14:0]); mul_b = 32'(r_lm[1][14:0]); end
                    6'd8:  begin mul_a = 32'(r_lm[2][14:0]); mul_b = 32'(r_lm[2][14:0]); end
                    6'd10: begin mul_a = r_nn;               mul_b = r_ll; end
                    6'd11: begin mul_a = r_dot[31:0];        mul_b = r_dot[31:0]; end
                    6'd13: begin mul_a = r_d2[31:0];         mul_b = LEVEL_SQ; end
                    6'd14: begin mul_a = r_d2[63:32];        mul_b = LEVEL_SQ; end
                    default: begin mul_a = '0;               mul_b = '0; end
                endcase
            end
            S_SRCH: begin
                case (r_pc)
                    6'd0:    begin mul_a = 32'(k_try);   mul_b = 32'(k_try); end
                    6'd1:    begin mul_a = r_pr[31:0];   mul_b = 32'(r_prod[15:0]); end
                    6'd2:    begin mul_a = r_pr[63:32];  mul_b = 32'(r_tsq); end
                    default: begin mul_a = '0;           mul_b = '0; end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider step: one quotient bit per cycle.
    always_comb begin
        div_d  = r_dsel ? i_cfg.dm1 : i_cfg.wm1;
        rem_sh = {r_drem, r_dnum[QW-1]};
        div_ge = rem_sh >= {1'b0, div_d};
        rem_nx = div_ge ? rem_sh - {1'b0, div_d} : rem_sh;
        q_nx   = {r_dnum[QW-2:0], div_ge};
    end

    // Light vector components in Q.16.
    always_comb begin
        lp_x   = {{2{i_cfg.lx[CFG_W-1]}}, i_cfg.lx, 8'd0};
        lp_y   = {{2{i_cfg.ly[CFG_W-1]}}, i_cfg.ly, 8'd0};
        lp_z   = {{2{i_cfg.lz[CFG_W-1]}}, i_cfg.lz, 8'd0};
        l0_val = axneg ? lp_x + {2'b0, q_nx[31:0]} : lp_x - {2'b0, q_nx[31:0]};
        l1_val = lp_y - {2'b0, r_py};
        l2_val = azneg ? lp_z + {2'b0, q_nx[31:0]} : lp_z - {2'b0, q_nx[31:0]};
    end

    // Signed dot product term and search compare.
    always_comb begin
        dot_term = {2'b0, r_prod[31:0]};
        term_neg = 1'b0;
        case (r_pc)
            6'd1:    term_neg = r_ns[0] ^ r_ls[0];
            6'd2:    term_neg = r_ns[1] ^ r_ls[1];
            6'd3:    term_neg = r_ns[2] ^ r_ls[2];
            default: term_neg = 1'b0;
        endcase
        dot_pos = !r_dot[33] && (r_dot != '0);
        k_try   = r_k | r_bit;
        lhs     = {r_prod[47:0], 32'd0} + {32'd0, r_lo};
    end

    assign o_q_pop  = (r_st == S_IDLE) && i_q_valid;
    assign o_busy   = (r_st != S_IDLE);
    assign res_load = (r_st == S_DONE) && (!r_ovalid || i_ready);

    // Shared multiplier output register.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_pc     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_x  <= i_q_item.x;
                        r_z  <= i_q_item.z;
                        r_pc <= '0;
                        r_st <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_pc != '0) begin
                        r_h[r_pc[2:0] - 3'd1] <= i_rd_data;
                    end
                    if (r_pc == 6'd5) begin
                        r_pc <= '0;
                        r_st <= S_MUL;
                    end else begin
                        r_pc <= r_pc + 6'd1;
                    end
                end
                S_MUL: begin
                    r_pc <= r_pc + 6'd1;
                    case (r_pc)
                        6'd1: r_dyx <= r_prod[DY_SHIFT+27:DY_SHIFT];
                        6'd2: r_dyz <= r_prod[DY_SHIFT+27:DY_SHIFT];
                        6'd3: r_py  <= r_prod[PY_SHIFT+31:PY_SHIFT];
                        6'd4: r_t1  <= r_prod[31:0];
                        6'd5: r_t2  <= r_prod[31:0];
                        6'd6: begin
                            r_nm[0] <= r_prod[NW-1:0];
                            r_ns[0] <= dx_pos;
                        end
                        6'd7: begin
                            r_nm[2] <= r_prod[NW-1:0];
                            r_ns[2] <= dz_pos;
                        end
                        6'd8: begin
                            r_nm[1] <= {r_prod[NW-6:0], 5'd0};
                            r_ns[1] <= 1'b0;
                        end
                        6'd9: r_numx <= {r_prod[QW-8:0], 7'd0};
                        6'd10: begin
                            r_numz  <= {r_prod[QW-8:0], 7'd0};
                            r_lm[1] <= mag34(l1_val);
                            r_ls[1] <= l1_val[33];
                            r_dnum  <= r_numx;
                            r_drem  <= '0;
                            r_dsel  <= 1'b0;
                            r_pc    <= '0;
                            r_st    <= S_DIV;
                        end
                        default: r_t1 <= r_t1;
                    endcase
                end
                S_DIV: begin
                    r_dnum <= q_nx;
                    r_drem <= rem_nx[IDX_W-1:0];
                    r_pc   <= r_pc + 6'd1;
                    if (r_pc == DIV_LAST) begin
                        r_pc <= '0;
                        if (!r_dsel) begin
                            r_lm[0] <= mag34(l0_val);
                            r_ls[0] <= l0_val[33];
                            r_dnum  <= r_numz;
                            r_drem  <= '0;
                            r_dsel  <= 1'b1;
                        end else begin
                            r_lm[2] <= mag34(l2_val);
                            r_ls[2] <= l2_val[33];
                            r_st    <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    // Common shift per vector until every magnitude is below 2^15.
                    for (int i = 0; i < 3; i++) begin
                        if (n_b8) begin
                            r_nm[i] <= r_nm[i] >> 8;
                        end else if (n_b1) begin
                            r_nm[i] <= r_nm[i] >> 1;
                        end
                        if (l_b8) begin
                            r_lm[i] <= r_lm[i] >> 8;
                        end else if (l_b1) begin
                            r_lm[i] <= r_lm[i] >> 1;
                        end
                    end
                    if (!n_b1 && !l_b1) begin
                        r_pc <= '0;
                        r_st <= S_DOT;
                    end
                end
                S_DOT: begin
                    r_pc <= r_pc + 6'd1;
                    case (r_pc)
                        6'd1:  r_dot <= term_neg ? 34'd0 - dot_term : dot_term;
                        6'd2,
                        6'd3:  r_dot <= term_neg ? r_dot - dot_term : r_dot + dot_term;
                        6'd4:  r_nn  <= r_prod[31:0];
                        6'd5,
                        6'd6:  r_nn  <= r_nn + r_prod[31:0];
                        6'd7:  r_ll  <= r_prod[31:0];
                        6'd8,
                        6'd9:  r_ll  <= r_ll + r_prod[31:0];
                        6'd11: r_pr  <= r_prod;
                        6'd12: r_d2  <= r_prod;
                        6'd14: r_lo  <= r_prod[47:0];
                        6'd15: begin
                            r_rhs <= {r_prod[47:0], 32'd0} + {32'd0, r_lo};
                            r_k   <= '0;
                            r_bit <= 8'h80;
                            r_pc  <= '0;
                            if (okn && okl && dot_pos) begin
                                r_st <= S_SRCH;
                            end else begin
                                r_st <= S_DONE;
                            end
                        end
                        default: r_nn <= r_nn;
                    endcase
                end
                S_SRCH: begin
                    // One intensity bit per pass, tested against the exact square.
                    r_pc <= r_pc + 6'd1;
                    case (r_pc)
                        6'd1: r_tsq <= r_prod[15:0];
                        6'd2: r_lo  <= r_prod[47:0];
                        6'd3: begin
                            if (lhs <= r_rhs) begin
                                r_k <= k_try;
                            end
                            r_bit <= r_bit >> 1;
                            r_pc  <= '0;
                            if (r_bit == 8'h01) begin
                                r_st <= S_DONE;
                            end
                        end
                        default: r_tsq <= r_tsq;
                    endcase
                end
                S_DONE: begin
                    if (res_load) begin
                        r_ovalid <= 1'b1;
                        r_oint   <= r_k;
                        r_ox     <= r_x;
                        r_oz     <= r_z;
                        r_st     <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_intensity = r_oint;
    assign o_grid_x    = r_ox;
    assign o_grid_z    = r_oz;

    // The intensity search tests exactly one bit at a time.
    a_srch_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_SRCH) |-> $onehot(r_bit))
        else $error("search bit is not one-hot");

    // The divider remainder always stays below the divisor.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_DIV) |-> (r_drem < div_d))
        else $error("divider remainder out of range");

    // After reduction every normal and light component fits the dot product width.
    a_red_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_DOT) |-> (r_nm[0][NW-1:15] == '0 && r_nm[1][NW-1:15] == '0 &&
                             r_nm[2][NW-1:15] == '0 && r_lm[0][32:15] == '0 &&
                             r_lm[1][32:15] == '0 && r_lm[2][32:15] == '0))
        else $error("vector not reduced before dot product");

endmodule

`default_nettype wire

// ===== rtl/heightmap_diffuse_shader.sv =====
// ----------------------------------------------------------------------------
// heightmap_diffuse_shader
// Heightmap store with Lambert diffuse shading of grid points.
// ----------------------------------------------------------------------------
// A load request writes one height into the store as it is accepted; it
// is held off while an earlier shade is still queued or in progress. A
// shade request enters a two-entry queue; once the back end takes it, the
// result is built by store reads, multiplies on the shared 32x32
// multiplier, two bit-serial divisions for the centered position, vector
// reduction, dot product and squares, and a bit-by-bit intensity search on
// the same multiplier. The result register lets the next shade start while
// a finished result waits. The height store has no reset; reading a point
// whose neighbors were never loaded gives an undefined intensity.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_diffuse_shader (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [hds_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [hds_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic                            i_func,
    input  wire logic [hds_pkg::IDX_W-1:0]       i_x_index,
    input  wire logic [hds_pkg::IDX_W-1:0]       i_z_index,
    input  wire logic [hds_pkg::HEIGHT_BITS-1:0] i_height_value,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [hds_pkg::IDX_W-1:0]            o_intensity,
    output logic [hds_pkg::IDX_W-1:0]            o_grid_x,
    output logic [hds_pkg::IDX_W-1:0]            o_grid_z
);

    import hds_pkg::*;

    logic [DIM_W-1:0]       r_gw;
    logic [DIM_W-1:0]       r_gd;
    logic [CFG_W-1:0]       r_wx, r_wy, r_wz;
    logic [CFG_W-1:0]       r_lx, r_ly, r_lz;
    t_cfg                   cfg;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [HEIGHT_BITS-1:0] wr_data;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [HEIGHT_BITS-1:0] rd_data;
    logic                   q_valid;
    t_shade                 q_item;
    logic                   q_pop;
    logic                   back_busy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= GRID_LIM;
            r_gd <= GRID_LIM;
            r_wx <= 24'd65536;
            r_wy <= 24'd65536;
            r_wz <= 24'd65536;
            r_lx <= '0;
            r_ly <= '0;
            r_lz <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GRID_WIDTH:   r_gw <= i_cfg_data[DIM_W-1:0];
                REG_GRID_DEPTH:   r_gd <= i_cfg_data[DIM_W-1:0];
                REG_WORLD_SIZE_X: r_wx <= i_cfg_data;
                REG_WORLD_SIZE_Y: r_wy <= i_cfg_data;
                REG_WORLD_SIZE_Z: r_wz <= i_cfg_data;
                REG_LIGHT_POS_X:  r_lx <= i_cfg_data;
                REG_LIGHT_POS_Y:  r_ly <= i_cfg_data;
                REG_LIGHT_POS_Z:  r_lz <= i_cfg_data;
                default:          r_gw <= r_gw;
            endcase
        end
    end

    // Grid sizes clamped to the supported range, as last column and row.
    always_comb begin
        if (r_gw < GRID_MIN) begin
            cfg.wm1 = IDX_W'(GRID_MIN - 9'd1);
        end else if (r_gw > GRID_LIM) begin
            cfg.wm1 = IDX_W'(GRID_LIM - 9'd1);
        end else begin
            cfg.wm1 = IDX_W'(r_gw - 9'd1);
        end
        if (r_gd < GRID_MIN) begin
            cfg.dm1 = IDX_W'(GRID_MIN - 9'd1);
        end else if (r_gd > GRID_LIM) begin
            cfg.dm1 = IDX_W'(GRID_LIM - 9'd1);
        end else begin
            cfg.dm1 = IDX_W'(r_gd - 9'd1);
        end
        cfg.wx = r_wx;
        cfg.wy = r_wy;
        cfg.wz = r_wz;
        cfg.lx = r_lx;
        cfg.ly = r_ly;
        cfg.lz = r_lz;
    end

    hds_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_x_index      (i_x_index),
        .i_z_index      (i_z_index),
        .i_height_value (i_height_value),
        .i_back_busy    (back_busy),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_q_valid      (q_valid),
        .o_q_item       (q_item),
        .i_q_pop        (q_pop)
    );

    hds_ram #(
        .WIDTH (HEIGHT_BITS),
        .DEPTH (CELLS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    hds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_busy      (back_busy),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_intensity (o_intensity),
        .o_grid_x    (o_grid_x),
        .o_grid_z    (o_grid_z)
    );

endmodule

`default_nettype wire
